// ===== hw/rtl/pwtt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwtt_pkg
// Shared types, constants and arithmetic helpers of the PID/twiddle unit.
// ----------------------------------------------------------------------------
package pwtt_pkg;

	localparam int ErrW   = 16;
	localparam int GainW  = 24;
	localparam int IntegW = 32;
	localparam int PhaseW = 4;
	localparam int CfgIdxW = 3;

	localparam logic [PhaseW-1:0] PHASE_LAST = 4'd8;
	localparam logic [27:0] TUNE_IDLE_SUM5 = 28'd65536;
	localparam logic [15:0] ERR_ONE = 16'd4096;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_PROP_GAIN  = 3'd0,
		CFG_INTEG_GAIN = 3'd1,
		CFG_DERIV_GAIN = 3'd2,
		CFG_PROP_STEP  = 3'd3,
		CFG_INTEG_STEP = 3'd4,
		CFG_DERIV_STEP = 3'd5,
		CFG_STEER_MODE = 3'd6
	} cfg_reg_t;

	typedef enum logic {
		OP_UPDATE = 1'b0,
		OP_TUNE   = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		TW_RECORD    = 2'd0,
		TW_TRY_PLUS  = 2'd1,
		TW_TRY_MINUS = 2'd2
	} tw_sub_t;

	// stage 2: state already updated, operands for the products
	typedef struct packed {
		op_t                      op;
		logic signed [15:0]       err;
		logic signed [31:0]       integ;
		logic signed [16:0]       diff;
		logic signed [23:0]       gain0;
		logic signed [23:0]       gain1;
		logic signed [23:0]       gain2;
		logic [PhaseW-1:0]        phase;
	} s2_word_t;

	// stage 3: registered products
	typedef struct packed {
		op_t                      op;
		logic signed [39:0]       p0;
		logic signed [55:0]       p1;
		logic signed [40:0]       p2;
		logic signed [23:0]       gain0;
		logic signed [23:0]       gain1;
		logic signed [23:0]       gain2;
		logic [PhaseW-1:0]        phase;
	} s3_word_t;

	// unsigned divide by ten, exact for any 32-bit input
	function automatic logic [28:0] div10(input logic [31:0] x);
		logic [63:0] p;
		p = 64'(x) * 64'hCCCC_CCCD;
		return p[63:35];
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [27:0] v);
		logic signed [27:0] lo;
		logic signed [27:0] hi;
		lo = -28'sd8388608;
		hi = 28'sd8388607;
		if (v < lo)
			return 24'sh800000;
		else if (v > hi)
			return 24'sh7FFFFF;
		else
			return 24'(v);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [33:0] lo;
		logic signed [33:0] hi;
		lo = -34'sd2147483648;
		hi = 34'sd2147483647;
		if (v < lo)
			return 32'sh8000_0000;
		else if (v > hi)
			return 32'sh7FFF_FFFF;
		else
			return 32'(v);
	endfunction

	// step magnitude * num / 10, round half away from zero, sign kept
	function automatic logic signed [23:0] scale_step(input logic signed [23:0] dp,
		input logic [3:0] num);
		logic [23:0] m;
		logic [27:0] x;
		logic [28:0] r;
		logic signed [27:0] sr;
		m = dp[23] ? 24'(-dp) : 24'(dp);
		x = 28'(m) * 28'(num) + 28'd5;
		r = div10({4'd0, x});
		sr = dp[23] ? -28'(r) : 28'(r);
		return sat24(sr);
	endfunction

endpackage

// ===== hw/rtl/pid_with_twiddle_tuner_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_with_twiddle_tuner_unit
// PID drive computation with a nine-phase twiddle gain search.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_*) takes one word per error sample: tuser selects the
//   operation (0 drive update, 1 twiddle step), tdata holds the Q3.12 error.
//   Master channel (m_*) returns one word per input word: Q1.14 drive, the
//   three Q7.16 gains after the word and the twiddle phase.
//   cfg_we/cfg_index/cfg_wdata write the initial gains and steps (loaded into
//   the working gains/steps at once) and steer mode; write only when idle.
// Path: a word accepted on s_* passes the input register, the state update,
//   the product register and the output register before it shows on m_tdata.
// Throughput: one word per cycle while the output is not stalled. Controller and
//   twiddle state update from the input register as the word moves into
//   stage 2; the drive math follows in two stages that do not feed back.
// Reset: gains, steps, integral, previous error, best error, phase and steer
//   mode go to zero; all pipeline stages empty.
// Stall: each stage holds while the next is full and stalled; behind a
//   stalled result the empty stages keep filling, and s_tready drops only
//   when all four stages are full.
// ----------------------------------------------------------------------------
module pid_with_twiddle_tuner_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [15:0]  s_tdata,   // [15:0] cross_track_error
	input  logic         s_tuser,   // [0] operation
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,   // [15:0] drive, [39:16] prop_gain,
	                                // [63:40] integ_gain, [87:64] deriv_gain,
	                                // [91:88] tune_phase, [95:92] zero
	input  logic         cfg_we,
	input  logic [pwtt_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [23:0]  cfg_wdata
);

	// stage valids and handshake
	logic v1_q, v2_q, v3_q, v4_q;
	logic rdy1, rdy2, rdy3, rdy4;
	logic adv1, adv2, adv3;

	// input register
	pwtt_pkg::op_t      op_s1;
	logic signed [15:0] err_s1;

	// controller state
	logic signed [15:0] prev_q;
	logic signed [31:0] integ_q;
	logic signed [23:0] gain_q [3];
	logic signed [23:0] step_q [3];
	logic [31:0]        best_q;
	logic [pwtt_pkg::PhaseW-1:0] phase_q;
	logic               steer_q;

	// next state
	logic signed [15:0] prev_n;
	logic signed [31:0] integ_n;
	logic signed [23:0] gain_n [3];
	logic signed [23:0] step_n [3];
	logic [31:0]        best_n;
	logic [pwtt_pkg::PhaseW-1:0] phase_n;

	// update path
	logic        opposite;
	logic [31:0] i_abs;
	logic [28:0] i_div;
	logic signed [33:0] i_damp;
	logic signed [15:0] prev_eff;
	logic signed [16:0] diff;

	// tune path
	logic [pwtt_pkg::PhaseW-1:0] k;
	logic [pwtt_pkg::PhaseW-1:0] k_inc;
	logic [pwtt_pkg::PhaseW-1:0] k_skip;
	logic [1:0]         gi;
	pwtt_pkg::tw_sub_t  sub;
	logic signed [25:0] step_sum;
	logic [25:0]        sum_mag;
	logic [15:0]        e_mag;
	logic               tune_idle;
	logic [31:0]        err_sq;
	logic signed [23:0] g_sel;
	logic signed [23:0] s_sel;
	logic signed [23:0] g_plus;
	logic signed [23:0] g_back;
	logic signed [23:0] s_up;
	logic signed [23:0] s_down;

	pwtt_pkg::s2_word_t s2_s2;
	pwtt_pkg::s3_word_t s3_s3;

	// output stage
	logic signed [57:0] acc;
	logic signed [29:0] acc_c;
	logic signed [30:0] rnd;
	logic signed [15:0] drive_s4;
	logic signed [23:0] gain0_s4, gain1_s4, gain2_s4;
	logic [pwtt_pkg::PhaseW-1:0] phase_s4;

	assign rdy4 = !v4_q || m_tready;
	assign rdy3 = !v3_q || rdy4;
	assign rdy2 = !v2_q || rdy3;
	assign rdy1 = !v1_q || rdy2;
	assign adv1 = v1_q && rdy2;
	assign adv2 = v2_q && rdy3;
	assign adv3 = v3_q && rdy4;
	assign s_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			if (rdy1)
				v1_q <= s_tvalid;
			if (rdy2)
				v2_q <= v1_q;
			if (rdy3)
				v3_q <= v2_q;
			if (rdy4)
				v4_q <= v3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && rdy1) begin
			op_s1  <= pwtt_pkg::op_t'(s_tuser);
			err_s1 <= $signed(s_tdata);
		end
	end

	// ---- update path ----
	always_comb begin
		opposite = steer_q && ((integ_q < 0 && err_s1 > 0) || (integ_q > 0 && err_s1 < 0));
		i_abs    = integ_q[31] ? 32'(-integ_q) : 32'(integ_q);
		i_div    = pwtt_pkg::div10(i_abs);
		if (!opposite)
			i_damp = 34'(integ_q);
		else if (integ_q[31])
			i_damp = 34'(i_div);
		else
			i_damp = -34'(i_div);
		prev_eff = (prev_q == 16'sd0) ? err_s1 : prev_q;
		diff     = 17'(err_s1) - 17'(prev_eff);
	end

	// ---- twiddle path ----
	always_comb begin
		k = (phase_q > pwtt_pkg::PHASE_LAST) ? '0 : phase_q;
		if (k < 4'd3)
			gi = 2'd0;
		else if (k < 4'd6)
			gi = 2'd1;
		else
			gi = 2'd2;
		sub    = pwtt_pkg::tw_sub_t'(2'(k - 4'(gi) * 4'd3));
		k_inc  = (k == pwtt_pkg::PHASE_LAST) ? '0 : k + 4'd1;
		k_skip = (k + 4'd2 > pwtt_pkg::PHASE_LAST) ? k + 4'd2 - 4'd9 : k + 4'd2;
		step_sum = 26'(step_q[0]) + 26'(step_q[1]) + 26'(step_q[2]);
		sum_mag  = step_sum[25] ? 26'(-step_sum) : 26'(step_sum);
		e_mag    = err_s1[15] ? 16'(-err_s1) : 16'(err_s1);
		tune_idle = (28'(sum_mag) * 28'd5 < pwtt_pkg::TUNE_IDLE_SUM5)
			&& (e_mag < pwtt_pkg::ERR_ONE);
		err_sq = 32'(32'(err_s1) * 32'(err_s1));
		g_sel  = gain_q[gi];
		s_sel  = step_q[gi];
		g_plus = pwtt_pkg::sat24(28'(g_sel) + 28'(s_sel));
		g_back = pwtt_pkg::sat24(28'(g_plus) - (28'(s_sel) <<< 1));
		s_up   = pwtt_pkg::scale_step(s_sel, 4'd11);
		s_down = pwtt_pkg::scale_step(s_sel, 4'd9);
	end

	// ---- next state ----
	always_comb begin
		prev_n  = prev_q;
		integ_n = integ_q;
		gain_n  = gain_q;
		step_n  = step_q;
		best_n  = best_q;
		phase_n = phase_q;
		if (op_s1 == pwtt_pkg::OP_UPDATE) begin
			prev_n  = err_s1;
			integ_n = pwtt_pkg::sat32(i_damp + 34'(err_s1));
		end else if (tune_idle) begin
			phase_n = k;
		end else begin
			phase_n = k_inc;
			unique case (sub)
				pwtt_pkg::TW_RECORD: begin
					best_n = err_sq;
				end
				pwtt_pkg::TW_TRY_PLUS: begin
					if (err_sq <= best_q) begin
						gain_n[gi] = g_plus;
						step_n[gi] = s_up;
						phase_n    = k_skip;
					end else begin
						gain_n[gi] = g_back;
					end
				end
				pwtt_pkg::TW_TRY_MINUS: begin
					if (err_sq < best_q) begin
						step_n[gi] = s_up;
					end else begin
						gain_n[gi] = g_plus;
						step_n[gi] = s_down;
					end
				end
				default: begin
					phase_n = k;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			integ_q <= '0;
			for (int j = 0; j < 3; j++) begin
				gain_q[j] <= '0;
				step_q[j] <= '0;
			end
			best_q  <= '0;
			phase_q <= '0;
			steer_q <= 1'b0;
		end else begin
			if (adv1) begin
				prev_q  <= prev_n;
				integ_q <= integ_n;
				gain_q  <= gain_n;
				step_q  <= step_n;
				best_q  <= best_n;
				phase_q <= phase_n;
			end
			if (cfg_we) begin
				unique case (pwtt_pkg::cfg_reg_t'(cfg_index))
					pwtt_pkg::CFG_PROP_GAIN:  gain_q[0] <= $signed(cfg_wdata);
					pwtt_pkg::CFG_INTEG_GAIN: gain_q[1] <= $signed(cfg_wdata);
					pwtt_pkg::CFG_DERIV_GAIN: gain_q[2] <= $signed(cfg_wdata);
					pwtt_pkg::CFG_PROP_STEP:  step_q[0] <= $signed(cfg_wdata);
					pwtt_pkg::CFG_INTEG_STEP: step_q[1] <= $signed(cfg_wdata);
					pwtt_pkg::CFG_DERIV_STEP: step_q[2] <= $signed(cfg_wdata);
					pwtt_pkg::CFG_STEER_MODE: steer_q   <= cfg_wdata[0];
					default: ;
				endcase
			end
		end
	end

	// ---- stage 2: operands ----
	always_ff @(posedge clk) begin
		if (adv1) begin
			s2_s2.op    <= op_s1;
			s2_s2.err   <= err_s1;
			s2_s2.integ <= integ_n;
			s2_s2.diff  <= diff;
			s2_s2.gain0 <= gain_n[0];
			s2_s2.gain1 <= gain_n[1];
			s2_s2.gain2 <= gain_n[2];
			s2_s2.phase <= phase_n;
		end
	end

	// ---- stage 3: products ----
	always_ff @(posedge clk) begin
		if (adv2) begin
			s3_s3.op    <= s2_s2.op;
			s3_s3.p0    <= 40'(s2_s2.gain0) * 40'(s2_s2.err);
			s3_s3.p1    <= 56'(s2_s2.gain1) * 56'(s2_s2.integ);
			s3_s3.p2    <= 41'(s2_s2.gain2) * 41'(s2_s2.diff);
			s3_s3.gain0 <= s2_s2.gain0;
			s3_s3.gain1 <= s2_s2.gain1;
			s3_s3.gain2 <= s2_s2.gain2;
			s3_s3.phase <= s2_s2.phase;
		end
	end

	// ---- stage 4: sum, clamp to +/-1.0, round to Q1.14 ----
	always_comb begin
		acc = 58'(s3_s3.p0) + 58'(s3_s3.p1) - 58'(s3_s3.p2);
		if (acc > 58'sd268435456)
			acc_c = 30'sd268435456;
		else if (acc < -58'sd268435456)
			acc_c = -30'sd268435456;
		else
			acc_c = 30'(acc);
		rnd = 31'(acc_c) + 31'sd8192;
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			drive_s4 <= (s3_s3.op == pwtt_pkg::OP_TUNE) ? 16'sd0 : 16'(rnd >>> 14);
			gain0_s4 <= s3_s3.gain0;
			gain1_s4 <= s3_s3.gain1;
			gain2_s4 <= s3_s3.gain2;
			phase_s4 <= s3_s3.phase;
		end
	end

	assign m_tvalid = v4_q;
	assign m_tdata  = {4'd0, phase_s4, gain2_s4, gain1_s4, gain0_s4, drive_s4};

	// ---- assertions ----
	a_update_keeps_tuner: assert property (@(posedge clk) disable iff (!arst_n)
		adv1 && op_s1 == pwtt_pkg::OP_UPDATE && !cfg_we
		|=> $stable(phase_q) && $stable(best_q) && $stable(gain_q[0])
			&& $stable(gain_q[1]) && $stable(gain_q[2]))
		else $error("update word changed twiddle state");

	a_tune_keeps_loop: assert property (@(posedge clk) disable iff (!arst_n)
		adv1 && op_s1 == pwtt_pkg::OP_TUNE |=> $stable(prev_q) && $stable(integ_q))
		else $error("tune word changed integral or previous error");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		adv1 && op_s1 == pwtt_pkg::OP_TUNE |=> phase_q <= pwtt_pkg::PHASE_LAST)
		else $error("twiddle phase out of range");

	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> v1_q && v2_q && v3_q && v4_q && !m_tready)
		else $error("input blocked with a free stage");

endmodule

// ===== tb/pid_with_twiddle_tuner_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_with_twiddle_tuner_unit_tb
// Self-checking bench for the PID drive unit with twiddle gain search.
// Error words go in on the slave stream with the operation in tuser. A
// bit-accurate drive/twiddle predictor runs as each word is accepted, and
// every output word is compared against the oldest predicted word. The run
// steps through several gain/step/steer settings, loaded while the unit is
// idle: directed corner cases, random phases with backpressure on both
// sides, and a steady-error integrator run followed by steer damping.
// ----------------------------------------------------------------------------
module pid_with_twiddle_tuner_unit_tb;

	localparam longint GAIN_MAX = 64'sd8388607;
	localparam longint GAIN_MIN = -64'sd8388608;
	localparam longint INTEG_MAX = 64'sd2147483647;
	localparam longint INTEG_MIN = -64'sd2147483648;
	localparam longint ONE_Q28 = 64'sd268435456;
	localparam int HOLD_CYCLES = 80;

	typedef struct packed {
		logic [3:0]         phase;
		logic signed [23:0] deriv;
		logic signed [23:0] integ;
		logic signed [23:0] prop;
		logic signed [15:0] drive;
	} drive_word_t;

	typedef struct {
		pwtt_pkg::op_t      op;
		logic signed [15:0] err;
	} sample_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [pwtt_pkg::CfgIdxW-1:0] cfg_index = '0;
	logic [23:0] cfg_wdata = '0;

	pid_with_twiddle_tuner_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// controller state mirror
	longint tuned_gain[3];
	longint tuned_step[3];
	longint err_integral;
	longint last_err;
	longint best_sq_err;
	int     twiddle_phase;
	bit     steer_on;

	sample_t     sample_q[$];
	drive_word_t drive_q[$];
	drive_word_t want_word;
	drive_word_t got_word;
	sample_t     next_sample;

	int send_idle = 34;
	int recv_idle = 34;
	int stall_req = 0;
	int stall_ack = 0;
	int hold_left = 0;
	int n_accepted = 0;
	int n_tunes = 0;
	int n_results = 0;
	int n_mismatch = 0;
	int n_settings = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic longint clip_gain(longint v);
		if (v < GAIN_MIN)
			return GAIN_MIN;
		if (v > GAIN_MAX)
			return GAIN_MAX;
		return v;
	endfunction

	function automatic longint scaled_step(longint dp, longint num);
		longint m;
		longint r;
		m = (dp < 0) ? -dp : dp;
		r = (m * num + 5) / 10;
		return clip_gain((dp < 0) ? -r : r);
	endfunction

	function automatic drive_word_t next_drive_word(pwtt_pkg::op_t op,
		logic signed [15:0] e_in);
		drive_word_t w;
		longint e;
		longint diff;
		longint acc;
		longint sum;
		longint sq;
		int k;
		int i;
		e = longint'(e_in);
		w.drive = '0;
		if (op == pwtt_pkg::OP_TUNE) begin
			k = (twiddle_phase > 8) ? 0 : twiddle_phase;
			i = k / 3;
			sum = tuned_step[0] + tuned_step[1] + tuned_step[2];
			if (sum < 0)
				sum = -sum;
			if (!(sum * 5 < 65536 && ((e < 0) ? -e : e) < 4096)) begin
				sq = e * e;
				twiddle_phase = (k + 1) % 9;
				case (pwtt_pkg::tw_sub_t'(k % 3))
					pwtt_pkg::TW_RECORD: begin
						best_sq_err = sq;
					end
					pwtt_pkg::TW_TRY_PLUS: begin
						tuned_gain[i] = clip_gain(tuned_gain[i] + tuned_step[i]);
						if (sq <= best_sq_err) begin
							tuned_step[i] = scaled_step(tuned_step[i], 11);
							twiddle_phase = (k + 2) % 9;
						end else begin
							tuned_gain[i] = clip_gain(tuned_gain[i] - 2 * tuned_step[i]);
						end
					end
					default: begin
						if (sq < best_sq_err) begin
							tuned_step[i] = scaled_step(tuned_step[i], 11);
						end else begin
							tuned_gain[i] = clip_gain(tuned_gain[i] + tuned_step[i]);
							tuned_step[i] = scaled_step(tuned_step[i], 9);
						end
					end
				endcase
			end
		end else begin
			// steer damping: integral opposing the new error becomes -1/10 of itself
			if (steer_on && ((err_integral < 0 && e > 0) || (err_integral > 0 && e < 0)))
				err_integral = -(err_integral / 10);
			if (last_err == 0)
				last_err = e;
			diff = e - last_err;
			last_err = e;
			err_integral = err_integral + e;
			if (err_integral > INTEG_MAX)
				err_integral = INTEG_MAX;
			if (err_integral < INTEG_MIN)
				err_integral = INTEG_MIN;
			acc = tuned_gain[0] * e + tuned_gain[1] * err_integral - tuned_gain[2] * diff;
			if (acc > ONE_Q28)
				acc = ONE_Q28;
			if (acc < -ONE_Q28)
				acc = -ONE_Q28;
			w.drive = 16'(((acc + ONE_Q28 + 8192) >>> 14) - 16384);
		end
		w.prop = 24'(tuned_gain[0]);
		w.integ = 24'(tuned_gain[1]);
		w.deriv = 24'(tuned_gain[2]);
		w.phase = 4'(twiddle_phase);
		return w;
	endfunction

	// sender
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				drive_q.insert(drive_q.size(),
					next_drive_word(pwtt_pkg::op_t'(s_tuser), s_tdata));
				n_accepted++;
				if (pwtt_pkg::op_t'(s_tuser) == pwtt_pkg::OP_TUNE)
					n_tunes++;
			end
			if (!s_tvalid || s_tready) begin
				if (sample_q.size() > 0 && $urandom_range(99) >= send_idle) begin
					next_sample = sample_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= next_sample.op;
					s_tdata <= next_sample.err;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_results++;
				got_word = m_tdata[91:0];
				if (drive_q.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("mismatch: unexpected word %h", m_tdata);
				end else begin
					want_word = drive_q.pop_front();
					if (got_word.drive !== want_word.drive || got_word.prop !== want_word.prop
						|| got_word.integ !== want_word.integ
						|| got_word.deriv !== want_word.deriv
						|| got_word.phase !== want_word.phase || m_tdata[95:92] !== 4'd0) begin
						n_mismatch++;
						if (n_mismatch <= 10) begin
							$display("mismatch at word %0d (exp/got): drive %0d/%0d prop %0d/%0d",
								n_results, want_word.drive, got_word.drive,
								want_word.prop, got_word.prop);
							$display("  integ %0d/%0d deriv %0d/%0d phase %0d/%0d pad %h",
								want_word.integ, got_word.integ, want_word.deriv,
								got_word.deriv, want_word.phase, got_word.phase,
								m_tdata[95:92]);
						end
					end
				end
			end
			if (stall_ack != stall_req) begin
				stall_ack = stall_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	task automatic add_sample(pwtt_pkg::op_t op, longint e);
		sample_t s;
		s.op = op;
		s.err = 16'(e);
		sample_q.insert(sample_q.size(), s);
	endtask

	task automatic write_reg(pwtt_pkg::cfg_reg_t idx, longint val);
		logic signed [23:0] v24;
		v24 = 24'(val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v24;
		case (idx)
			pwtt_pkg::CFG_PROP_GAIN, pwtt_pkg::CFG_INTEG_GAIN,
			pwtt_pkg::CFG_DERIV_GAIN: tuned_gain[idx] = longint'(v24);
			pwtt_pkg::CFG_PROP_STEP, pwtt_pkg::CFG_INTEG_STEP,
			pwtt_pkg::CFG_DERIV_STEP: tuned_step[idx - 3] = longint'(v24);
			pwtt_pkg::CFG_STEER_MODE: steer_on = v24[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_config(longint g0, longint g1, longint g2, longint p0, longint p1,
		longint p2, bit steer);
		write_reg(pwtt_pkg::CFG_PROP_GAIN, g0);
		write_reg(pwtt_pkg::CFG_INTEG_GAIN, g1);
		write_reg(pwtt_pkg::CFG_DERIV_GAIN, g2);
		write_reg(pwtt_pkg::CFG_PROP_STEP, p0);
		write_reg(pwtt_pkg::CFG_INTEG_STEP, p1);
		write_reg(pwtt_pkg::CFG_DERIV_STEP, p2);
		write_reg(pwtt_pkg::CFG_STEER_MODE, steer);
		n_settings++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (sample_q.size() != 0 || s_tvalid || drive_q.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	function automatic longint rand_q816();
		logic signed [23:0] r;
		r = 24'($urandom);
		case ($urandom_range(5))
			0: return GAIN_MAX;
			1: return GAIN_MIN;
			2: return 0;
			3: return longint'($urandom_range(8000)) - 4000;
			4: return longint'(r);
			default: return ($urandom_range(1) ? 1 : -1) * longint'($urandom_range(300000, 1000));
		endcase
	endfunction

	function automatic longint rand_err();
		logic signed [15:0] r;
		r = 16'($urandom);
		case ($urandom_range(5))
			0: return longint'(r);
			1: return longint'($urandom_range(8190)) - 4095;
			2: return $urandom_range(1) ? 32767 : -32768;
			3: return 0;
			4: return longint'($urandom_range(32768)) - 16384;
			default: return longint'($urandom_range(600)) - 300;
		endcase
	endfunction

	initial begin
		tuned_gain = '{0, 0, 0};
		tuned_step = '{0, 0, 0};
		err_integral = 0;
		last_err = 0;
		best_sq_err = 0;
		twiddle_phase = 0;
		steer_on = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// all-zero settings out of reset: idle tunes and field extremes
		add_sample(pwtt_pkg::OP_UPDATE, 0);
		add_sample(pwtt_pkg::OP_UPDATE, 32767);
		add_sample(pwtt_pkg::OP_UPDATE, -32768);
		add_sample(pwtt_pkg::OP_TUNE, 100);
		add_sample(pwtt_pkg::OP_TUNE, -32768);
		add_sample(pwtt_pkg::OP_TUNE, 0);
		wait_drained();

		// drive rounding: exact halves of an LSB
		load_config(1, 0, 0, 0, 0, 0, 1'b0);
		add_sample(pwtt_pkg::OP_UPDATE, 8192);
		add_sample(pwtt_pkg::OP_UPDATE, -8192);
		wait_drained();

		// steer damping both ways, then a zero previous error
		load_config(0, 1, 100, 0, 0, 0, 1'b1);
		add_sample(pwtt_pkg::OP_UPDATE, 0);
		add_sample(pwtt_pkg::OP_UPDATE, 1000);
		add_sample(pwtt_pkg::OP_UPDATE, 3000);
		add_sample(pwtt_pkg::OP_UPDATE, -2000);
		add_sample(pwtt_pkg::OP_UPDATE, 5000);
		add_sample(pwtt_pkg::OP_UPDATE, 0);
		add_sample(pwtt_pkg::OP_UPDATE, 700);
		wait_drained();

		// rail gains and steps: gain and step saturation through the search
		load_config(GAIN_MAX, GAIN_MIN, GAIN_MAX, GAIN_MAX, GAIN_MIN, GAIN_MAX, 1'b0);
		add_sample(pwtt_pkg::OP_TUNE, -32768);
		add_sample(pwtt_pkg::OP_TUNE, 32767);
		add_sample(pwtt_pkg::OP_TUNE, 100);
		add_sample(pwtt_pkg::OP_TUNE, 0);
		add_sample(pwtt_pkg::OP_TUNE, 20000);
		add_sample(pwtt_pkg::OP_UPDATE, 32767);
		add_sample(pwtt_pkg::OP_TUNE, -5);
		add_sample(pwtt_pkg::OP_TUNE, 9000);
		add_sample(pwtt_pkg::OP_TUNE, -32768);
		add_sample(pwtt_pkg::OP_UPDATE, -32768);
		add_sample(pwtt_pkg::OP_TUNE, 4096);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			load_config(rand_q816(), rand_q816(), rand_q816(), rand_q816(), rand_q816(),
				rand_q816(), 1'($urandom_range(1)));
			send_idle = (ph < 2) ? 0 : 34;
			recv_idle = (ph == 1) ? 0 : 34;
			for (int n = 0; n < 120; n++)
				add_sample(($urandom_range(99) < 40) ? pwtt_pkg::OP_TUNE : pwtt_pkg::OP_UPDATE,
					rand_err());
			if (ph == 0)
				stall_req = stall_req + 1;
			wait_drained();
		end

		// steady error winds the integral up, then steer damping flips it on the way down
		load_config(100, 1, 50, 0, 0, 0, 1'b0);
		for (int n = 0; n < 60; n++)
			add_sample(pwtt_pkg::OP_UPDATE, 32767);
		wait_drained();
		write_reg(pwtt_pkg::CFG_STEER_MODE, 1);
		@(negedge clk);
		for (int n = 0; n < 40; n++)
			add_sample(pwtt_pkg::OP_UPDATE, -32768);
		wait_drained();

		$display("summary: %0d words accepted (%0d tune steps), %0d results checked,",
			n_accepted, n_tunes, n_results);
		$display("summary: %0d register settings, %0d mismatches", n_settings, n_mismatch);
		if (n_mismatch == 0 && drive_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
